### rtl/tdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpc_pkg;

    // Field and register widths
    localparam int IW_W    = 13;   // image_width register
    localparam int TS_W    = 7;    // tile_width / tile_height registers
    localparam int THR_W   = 9;    // dark_threshold register
    localparam int PIX_W   = 8;    // one color channel
    localparam int PX_W    = 12;   // pixel_x
    localparam int SUB_W   = 6;    // line_in_tile / col_in_tile
    localparam int COL_W   = 8;    // tile column index
    localparam int ROW_W   = 12;   // tile row index
    localparam int CNT_W   = 13;   // dark count
    localparam int NCOL_W  = 9;    // tile columns per line, up to MAX_TILE_COLS
    localparam int CFG_W   = 13;   // widest register
    localparam int IDX_W   = 2;

    localparam int MAX_TILE_COLS   = 256;
    localparam int MAX_TILE_SIDE   = 64;
    localparam int MAX_IMAGE_WIDTH = 4096;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_TILE_WIDTH     = 2'd1;
    localparam logic [IDX_W-1:0] REG_TILE_HEIGHT    = 2'd2;
    localparam logic [IDX_W-1:0] REG_DARK_THRESHOLD = 2'd3;

    // Reset values
    localparam int RST_IMAGE_WIDTH    = 640;
    localparam int RST_TILE_WIDTH     = 16;
    localparam int RST_TILE_HEIGHT    = 16;
    localparam int RST_DARK_THRESHOLD = 20;
    localparam int RST_NCOLS_RAW      = RST_IMAGE_WIDTH / RST_TILE_WIDTH;
    localparam int RST_NCOLS          = (RST_NCOLS_RAW > MAX_TILE_COLS) ?
                                        MAX_TILE_COLS : RST_NCOLS_RAW;
    localparam int RST_SPAN           = RST_NCOLS * RST_TILE_WIDTH;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        GEOM_IDLE,
        GEOM_DIV,
        GEOM_CLAMP,
        GEOM_MUL
    } geom_state_t;

    // Line geometry derived from the registers
    typedef struct packed {
        logic [NCOL_W-1:0] ncols;   // full tile columns, clamped
        logic [IW_W-1:0]   span;    // ncols * tile width, in pixels
    } geom_t;

    typedef struct packed {
        logic [ROW_W-1:0] tile_row;
        logic [COL_W-1:0] tile_col;
        logic [CNT_W-1:0] dark_count;
        logic             row_last;
    } result_t;

endpackage

`default_nettype wire

### rtl/tile_dark_pixel_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload (low bit first)                         Handshake
// s_axis    in   tdata: blue[7:0] green[15:8] red[23:16]        tvalid/tready
//                tuser: start_of_frame
// m_axis    out  tdata: tile_row[11:0] tile_col[19:12]          tvalid/tready
//                       dark_count[32:20], zero fill [39:33]
//                tlast: row_last
// cfg       in   cfg_we, cfg_index, cfg_wdata                    write only
//
// One pixel per clock unless s_axis stalls. A pixel is accepted, its tile
// column's count is read from the count RAM, updated and written back the next
// cycle; back-to-back hits on one column are forwarded from the write register.
// A write to image_width or tile_width stalls s_axis while the
// serial divider recomputes tile columns per line (one quotient bit per cycle).
// Reset: registers take their defaults, per-column valid flops clear all at once
// (no clearing pass); start_of_frame clears them the same way.
// Results wait in a 4-entry queue; s_axis also stalls when that queue could fill.
module tile_dark_pixel_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // blue, green, red
    input  wire logic        s_axis_tuser,   // start_of_frame

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // tile_row, tile_col, dark_count
    output logic             m_axis_tlast,   // row_last

    input  wire logic                        cfg_we,
    input  wire logic [tdpc_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [tdpc_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int PX_W   = tdpc_pkg::PX_W;
    localparam int SUB_W  = tdpc_pkg::SUB_W;
    localparam int COL_W  = tdpc_pkg::COL_W;
    localparam int ROW_W  = tdpc_pkg::ROW_W;
    localparam int CNT_W  = tdpc_pkg::CNT_W;
    localparam int IW_W   = tdpc_pkg::IW_W;
    localparam int TS_W   = tdpc_pkg::TS_W;
    localparam int NCOL_W = tdpc_pkg::NCOL_W;
    localparam int FAW    = tdpc_pkg::FIFO_AW;

    // ---------------- configuration registers ----------------
    logic [IW_W-1:0]            image_width_reg;
    logic [TS_W-1:0]            tile_width_reg;
    logic [TS_W-1:0]            tile_height_reg;
    logic [tdpc_pkg::THR_W-1:0] dark_threshold_reg;
    logic                       geom_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IW_W'(tdpc_pkg::RST_IMAGE_WIDTH);
            tile_width_reg     <= TS_W'(tdpc_pkg::RST_TILE_WIDTH);
            tile_height_reg    <= TS_W'(tdpc_pkg::RST_TILE_HEIGHT);
            dark_threshold_reg <= tdpc_pkg::THR_W'(tdpc_pkg::RST_DARK_THRESHOLD);
            geom_start_reg     <= 1'b0;
        end
        else
        begin
            // divider starts the cycle after the write, on the new value
            geom_start_reg <= cfg_we && (cfg_index == tdpc_pkg::REG_IMAGE_WIDTH ||
                                         cfg_index == tdpc_pkg::REG_TILE_WIDTH);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tdpc_pkg::REG_IMAGE_WIDTH:    image_width_reg <= cfg_wdata;
                    tdpc_pkg::REG_TILE_WIDTH:     tile_width_reg  <= cfg_wdata[TS_W-1:0];
                    tdpc_pkg::REG_TILE_HEIGHT:    tile_height_reg <= cfg_wdata[TS_W-1:0];
                    tdpc_pkg::REG_DARK_THRESHOLD:
                        dark_threshold_reg <= cfg_wdata[tdpc_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamped register values
    logic [IW_W-1:0] iw_c;
    logic [TS_W-1:0] tw_c;
    logic [TS_W-1:0] th_c;

    always_comb
    begin
        if (image_width_reg == '0)
            iw_c = IW_W'(1);
        else if (image_width_reg > IW_W'(tdpc_pkg::MAX_IMAGE_WIDTH))
            iw_c = IW_W'(tdpc_pkg::MAX_IMAGE_WIDTH);
        else
            iw_c = image_width_reg;

        if (tile_width_reg == '0)
            tw_c = TS_W'(1);
        else if (tile_width_reg > TS_W'(tdpc_pkg::MAX_TILE_SIDE))
            tw_c = TS_W'(tdpc_pkg::MAX_TILE_SIDE);
        else
            tw_c = tile_width_reg;

        if (tile_height_reg == '0)
            th_c = TS_W'(1);
        else if (tile_height_reg > TS_W'(tdpc_pkg::MAX_TILE_SIDE))
            th_c = TS_W'(tdpc_pkg::MAX_TILE_SIDE);
        else
            th_c = tile_height_reg;
    end

    // ---------------- line geometry ----------------
    logic            geom_busy;
    tdpc_pkg::geom_t geom;

    tdpc_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (geom_start_reg),
        .iw    (iw_c),
        .tw    (tw_c),
        .busy  (geom_busy),
        .geom  (geom)
    );

    // ---------------- position tracking (accept stage) ----------------
    logic [PX_W-1:0]  pixel_x_reg;
    logic [SUB_W-1:0] line_in_tile_reg;
    logic [SUB_W-1:0] col_in_tile_reg;
    logic [COL_W-1:0] tile_col_reg;
    logic [ROW_W-1:0] tile_row_reg;

    logic [PX_W-1:0]  pixel_x_next;
    logic [SUB_W-1:0] line_in_tile_next;
    logic [SUB_W-1:0] col_in_tile_next;
    logic [COL_W-1:0] tile_col_next;
    logic [ROW_W-1:0] tile_row_next;

    logic             accept;
    logic             sof;
    logic [PX_W-1:0]  px;
    logic [SUB_W-1:0] lin;
    logic [SUB_W-1:0] cin;
    logic [COL_W-1:0] tcol;
    logic [ROW_W-1:0] trow;
    logic             last_col;
    logic             last_line;
    logic             line_wrap;
    logic             in_full;
    logic             in_first;
    logic             in_dark;
    logic             in_res;
    logic             in_row_last;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign sof    = s_axis_tuser;
    assign blue   = s_axis_tdata[7:0];
    assign green  = s_axis_tdata[15:8];
    assign red    = s_axis_tdata[23:16];

    always_comb
    begin
        // start of frame: the pixel is handled as (0,0)
        px   = sof ? '0 : pixel_x_reg;
        lin  = sof ? '0 : line_in_tile_reg;
        cin  = sof ? '0 : col_in_tile_reg;
        tcol = sof ? '0 : tile_col_reg;
        trow = sof ? '0 : tile_row_reg;

        last_col    = ({1'b0, cin} + TS_W'(1)) >= tw_c;
        last_line   = ({1'b0, lin} + TS_W'(1)) >= th_c;
        line_wrap   = ({1'b0, px} + IW_W'(1)) >= iw_c;
        in_full     = ({1'b0, px} < geom.span) && ({1'b0, tcol} < geom.ncols);
        in_first    = (lin == '0) && (cin == '0);
        in_res      = in_full && last_col && last_line;
        in_row_last = ({1'b0, tcol} + NCOL_W'(1)) == geom.ncols;
        in_dark     = ({1'b0, blue}  < dark_threshold_reg) &&
                      ({1'b0, green} < dark_threshold_reg) &&
                      ({1'b0, red}   < dark_threshold_reg);

        pixel_x_next      = px + PX_W'(1);
        line_in_tile_next = lin;
        col_in_tile_next  = cin + SUB_W'(1);
        tile_col_next     = tcol;
        tile_row_next     = trow;
        if (line_wrap)
        begin
            pixel_x_next     = '0;
            col_in_tile_next = '0;
            tile_col_next    = '0;
            if (last_line)
            begin
                line_in_tile_next = '0;
                tile_row_next     = trow + ROW_W'(1);
            end
            else
            begin
                line_in_tile_next = lin + SUB_W'(1);
            end
        end
        else if (last_col)
        begin
            col_in_tile_next = '0;
            if (tcol != {COL_W{1'b1}})
                tile_col_next = tcol + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_x_reg      <= '0;
            line_in_tile_reg <= '0;
            col_in_tile_reg  <= '0;
            tile_col_reg     <= '0;
            tile_row_reg     <= '0;
        end
        else if (accept)
        begin
            pixel_x_reg      <= pixel_x_next;
            line_in_tile_reg <= line_in_tile_next;
            col_in_tile_reg  <= col_in_tile_next;
            tile_col_reg     <= tile_col_next;
            tile_row_reg     <= tile_row_next;
        end
    end

    // ---------------- update stage ----------------
    logic             s1_valid_reg;
    logic             s1_full_reg;
    logic             s1_first_reg;
    logic             s1_dark_reg;
    logic             s1_res_reg;
    logic             s1_row_last_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [ROW_W-1:0] s1_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_full_reg     <= in_full;
            s1_first_reg    <= in_first;
            s1_dark_reg     <= in_dark;
            s1_res_reg      <= in_res;
            s1_row_last_reg <= in_row_last;
            s1_addr_reg     <= tcol;
            s1_row_reg      <= trow;
        end
    end

    // count RAM, one entry per tile column
    logic [CNT_W-1:0]         count_mem [tdpc_pkg::MAX_TILE_COLS];
    logic [CNT_W-1:0]         rdata_reg;
    logic [tdpc_pkg::MAX_TILE_COLS-1:0] valid_reg;
    logic [tdpc_pkg::MAX_TILE_COLS-1:0] valid_next;

    logic                     wr_en;
    logic [CNT_W-1:0]         old_count;
    logic [CNT_W-1:0]         base_count;
    logic [CNT_W-1:0]         new_count;
    logic                     fwd;
    logic                     wr_valid_reg;
    logic [COL_W-1:0]         wr_addr_reg;
    logic [CNT_W-1:0]         wr_data_reg;

    always_comb
    begin
        wr_en = s1_valid_reg && s1_full_reg;
        // last cycle's write has not reached the RAM read port yet
        fwd   = wr_valid_reg && (wr_addr_reg == s1_addr_reg);
        if (!valid_reg[s1_addr_reg])
            old_count = '0;
        else if (fwd)
            old_count = wr_data_reg;
        else
            old_count = rdata_reg;
        base_count = s1_first_reg ? '0 : old_count;
        new_count  = (s1_dark_reg && base_count != tdpc_pkg::COUNT_MAX) ?
                     base_count + CNT_W'(1) : base_count;

        valid_next = valid_reg;
        if (wr_en)
            valid_next[s1_addr_reg] = 1'b1;
        // frame start is younger than the write in flight: its clear wins
        if (accept && sof)
            valid_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= count_mem[tcol];
        if (wr_en)
            count_mem[s1_addr_reg] <= new_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            wr_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= new_count;
    end

    // ---------------- result queue ----------------
    tdpc_pkg::result_t fifo_mem [tdpc_pkg::FIFO_DEPTH];
    tdpc_pkg::result_t push_item;
    logic [FAW-1:0]    wr_ptr_reg;
    logic [FAW-1:0]    rd_ptr_reg;
    logic [FAW:0]      fifo_cnt_reg;
    logic              push;
    logic              pop;

    assign push = s1_valid_reg && s1_res_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        push_item.tile_row   = s1_row_reg;
        push_item.tile_col   = s1_addr_reg;
        push_item.dark_count = new_count;
        push_item.row_last   = s1_row_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + (FAW+1)'(push) - (FAW+1)'(pop);
        end
    end

    // room for the result in the update stage plus one more
    assign s_axis_tready = !geom_start_reg && !geom_busy &&
                           ((fifo_cnt_reg + (FAW+1)'(s1_valid_reg && s1_res_reg)) <
                            (FAW+1)'(tdpc_pkg::FIFO_DEPTH));

    tdpc_pkg::result_t head;

    always_comb
    begin
        head          = fifo_mem[rd_ptr_reg];
        m_axis_tvalid = fifo_cnt_reg != '0;
        m_axis_tdata  = {7'd0, head.dark_count, head.tile_col, head.tile_row};
        m_axis_tlast  = head.row_last;
    end

endmodule

`default_nettype wire

### rtl/tdpc_geom.sv
`timescale 1ns / 1ps
`default_nettype none

// ncols = min(iw / tw, MAX_TILE_COLS) by restoring division, then span = ncols * tw.
module tdpc_geom (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tdpc_pkg::IW_W-1:0]     iw,
    input  wire logic [tdpc_pkg::TS_W-1:0]     tw,
    output logic                               busy,
    output tdpc_pkg::geom_t                    geom
);

    localparam int STEP_W = $clog2(tdpc_pkg::IW_W);

    tdpc_pkg::geom_state_t state_reg, state_next;

    logic [STEP_W-1:0]            step_reg;
    logic [tdpc_pkg::IW_W-1:0]    quo_reg;
    logic [tdpc_pkg::TS_W-1:0]    rem_reg;
    logic [tdpc_pkg::NCOL_W-1:0]  ncols_reg;
    logic [tdpc_pkg::IW_W-1:0]    span_reg;

    logic [tdpc_pkg::TS_W:0]      trial;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[tdpc_pkg::IW_W-1]};
    assign fits  = trial >= {1'b0, tw};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdpc_pkg::GEOM_IDLE:  state_next = tdpc_pkg::GEOM_IDLE;
            tdpc_pkg::GEOM_DIV:
            begin
                if (step_reg == STEP_W'(tdpc_pkg::IW_W - 1))
                    state_next = tdpc_pkg::GEOM_CLAMP;
            end
            tdpc_pkg::GEOM_CLAMP: state_next = tdpc_pkg::GEOM_MUL;
            tdpc_pkg::GEOM_MUL:   state_next = tdpc_pkg::GEOM_IDLE;
            default:              state_next = tdpc_pkg::GEOM_IDLE;
        endcase
        if (start)
            state_next = tdpc_pkg::GEOM_DIV;
    end

    always_comb
    begin
        busy       = state_reg != tdpc_pkg::GEOM_IDLE;
        geom.ncols = ncols_reg;
        geom.span  = span_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdpc_pkg::GEOM_IDLE;
            ncols_reg <= tdpc_pkg::NCOL_W'(tdpc_pkg::RST_NCOLS);
            span_reg  <= tdpc_pkg::IW_W'(tdpc_pkg::RST_SPAN);
        end
        else
        begin
            state_reg <= state_next;
            if (!start && state_reg == tdpc_pkg::GEOM_CLAMP)
            begin
                if (quo_reg > tdpc_pkg::IW_W'(tdpc_pkg::MAX_TILE_COLS))
                    ncols_reg <= tdpc_pkg::NCOL_W'(tdpc_pkg::MAX_TILE_COLS);
                else
                    ncols_reg <= quo_reg[tdpc_pkg::NCOL_W-1:0];
            end
            if (!start && state_reg == tdpc_pkg::GEOM_MUL)
                span_reg <= tdpc_pkg::IW_W'(ncols_reg * tw);
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            step_reg <= '0;
            quo_reg  <= iw;
            rem_reg  <= '0;
        end
        else if (state_reg == tdpc_pkg::GEOM_DIV)
        begin
            step_reg <= step_reg + STEP_W'(1);
            quo_reg  <= {quo_reg[tdpc_pkg::IW_W-2:0], fits};
            rem_reg  <= fits ? tdpc_pkg::TS_W'(trial - {1'b0, tw})
                             : trial[tdpc_pkg::TS_W-1:0];
        end
    end

endmodule

`default_nettype wire
